@@ design/scl_pkg.sv @@
// Shared types and constants for the serial configuration loader.
package scl_pkg;

	localparam int unsigned TRAILER_PULSES = 6;
	localparam int unsigned MAX_RESULTS    = 8;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd8192;
	localparam logic [16:0] WAIT_MAX      = 17'h1FFFF;

	// Trailer lengths, cut so that no run exceeds the result limit.
	localparam int unsigned DONE_LEN    = (TRAILER_PULSES > MAX_RESULTS) ?
		MAX_RESULTS : TRAILER_PULSES;
	localparam int unsigned TIMEOUT_LEN = (TRAILER_PULSES > MAX_RESULTS - 1) ?
		MAX_RESULTS - 1 : TRAILER_PULSES;

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_DATA   = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_BUSY    = 2'd0,
		ST_STARTED = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	// Kind of result run that the back end plays out.
	typedef enum logic [1:0] {
		RUN_BEGIN = 2'd0,
		RUN_DATA  = 2'd1,
		RUN_PULSE = 2'd2,
		RUN_FLAT  = 2'd3
	} run_kind_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic       done_level;
	} item_t;

	typedef struct packed {
		logic       prog_level;
		logic       din_level;
		logic       clock_pulse;
		logic [1:0] load_status;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] data_byte;
		status_t    status;
		logic [2:0] last_idx;
	} run_t;

	localparam logic [2:0] DONE_LAST    = (DONE_LEN == 0) ? 3'd0 : 3'(DONE_LEN - 1);
	localparam logic [2:0] TIMEOUT_LAST = 3'(TIMEOUT_LEN);

endpackage

@@ design/scl_front.sv @@
// Front end: classify requests into result runs and track the done wait count.
module scl_front import scl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        accept,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output run_t        run,
	output logic        run_push
);

	logic [16:0] wait_count_q;
	logic [16:0] wait_next;
	logic [15:0] timeout_limit_q;

	always_comb begin
		run          = '0;
		run.kind     = RUN_PULSE;
		run.status   = ST_BUSY;
		run.last_idx = 3'd0;
		run.data_byte = item.data_byte;
		run_push     = accept;
		wait_next    = wait_count_q;
		unique case (action_t'(item.action))
			ACT_BEGIN: begin
				run.kind     = RUN_BEGIN;
				run.last_idx = 3'd1;
				wait_next    = '0;
			end
			ACT_DATA: begin
				run.kind     = RUN_DATA;
				run.last_idx = 3'd7;
			end
			ACT_FINISH: begin
				priority if (item.done_level) begin
					run.kind     = (DONE_LEN == 0) ? RUN_FLAT : RUN_PULSE;
					run.status   = ST_STARTED;
					run.last_idx = DONE_LAST;
					wait_next    = '0;
				end else if (wait_count_q > {1'b0, timeout_limit_q}) begin
					run.status   = ST_TIMEOUT;
					run.last_idx = TIMEOUT_LAST;
					wait_next    = '0;
				end else begin
					if (wait_count_q != WAIT_MAX) begin
						wait_next = wait_count_q + 17'd1;
					end
				end
			end
			ACT_NONE: begin
				// drop the request
				run_push = 1'b0;
			end
			default: run_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_count_q    <= '0;
			timeout_limit_q <= TIMEOUT_RESET;
		end else begin
			if (accept) begin
				wait_count_q <= wait_next;
			end
			if (cfg_we) begin
				timeout_limit_q <= cfg_data;
			end
		end
	end

endmodule

@@ design/scl_queue.sv @@
// Short run queue between front and back end.
module scl_queue import scl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  run_t wr_data,
	input  logic rd_en,
	output run_t rd_data,
	output logic full,
	output logic empty
);

	run_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/scl_back.sv @@
// Back end: plays runs into out_q, one result per cycle unless stalled.
module scl_back import scl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  run_t    head,
	input  logic    head_valid,
	output logic    head_take,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	run_t       cur_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res_next;
	logic       emit;
	logic       is_last;

	assign emit      = busy_q && (!out_valid_q || pop);
	assign is_last   = (idx_q == cur_q.last_idx);
	assign head_take = head_valid && (!busy_q || (emit && is_last));

	always_comb begin
		res_next             = '0;
		res_next.prog_level  = 1'b1;
		res_next.din_level   = 1'b1;
		res_next.clock_pulse = 1'b1;
		res_next.load_status = cur_q.status;
		res_next.last_of_run = is_last;
		unique case (cur_q.kind)
			RUN_BEGIN: begin
				res_next.prog_level  = (idx_q != 3'd0);
				res_next.clock_pulse = 1'b0;
			end
			RUN_DATA:  res_next.din_level = cur_q.data_byte[~idx_q];
			RUN_PULSE: res_next.clock_pulse = 1'b1;
			RUN_FLAT:  res_next.clock_pulse = 1'b0;
			default:   res_next.clock_pulse = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			cur_q <= head;
		end
		if (emit) begin
			out_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule

@@ design/serial_config_loader_unit.sv @@
// Top level of the slave-serial configuration link driver.
// A request's first result passes the run queue, the run register and the output
// register to the result ports. The sequencer gives one result per cycle unless the
// output stalls. Results per run: data eight, begin two, finish one, six or seven.
// Reset (arst_n low): run queue and output register empty, wait count zero,
// timeout_limit back to 8192.
module serial_config_loader_unit import scl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  item_t       item,
	// result side
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	// timeout_limit write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic accept;
	run_t run;
	logic run_push;
	run_t head;
	logic q_empty;
	logic head_take;

	// The user must change the register only while the link is idle; it is unchecked.
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Classify each request into a run descriptor; hold the wait count here so
	// that the timeout decision follows request order.
	scl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.run      (run),
		.run_push (run_push)
	);

	// Decouple classification from playback; full backs up to the request side.
	scl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (run_push),
		.wr_data (run),
		.rd_en   (head_take),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	// Advance through each run, one line-level result per cycle unless the output
	// stalls, loading the next run in the same cycle that the current run ends.
	scl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.head_take  (head_take),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
